// ===== sv/dda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer with depth test.
// Used by every module of the block but dda_ram; depends on nothing.
package dda_pkg;

    // Fixed-point and field widths.
    localparam int FRAC_W      = 16;
    localparam int LEN_W       = 16;
    localparam int DIV_W       = 34;
    localparam int STEP_XY_W   = 18;
    localparam int STEP_W_W    = 35;
    localparam int POS_W       = 35;
    localparam int WACC_W      = 36;
    localparam int COUNT_W     = 17;
    localparam int DEPTH_SHIFT = 24;
    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [31:0] FAR_RESET = 32'd167772;

    typedef enum logic [1:0] {
        ACT_DRAW       = 2'd0,
        ACT_FILL_DEPTH = 2'd1,
        ACT_FILL_COLOR = 2'd2,
        ACT_READ       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_W
    } div_sel_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PREP,
        F_DSTART,
        F_DWAIT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_DRAW,
        B_DRAIN,
        B_FILL,
        B_READ,
        B_READ_DATA,
        B_DONE
    } back_state_t;

    // One input beat, unpacked.
    typedef struct packed {
        action_t             action;
        logic signed [15:0]  start_x;
        logic signed [15:0]  start_y;
        logic signed [31:0]  start_w;
        logic signed [15:0]  end_x;
        logic signed [15:0]  end_y;
        logic signed [31:0]  end_w;
        logic [7:0]          line_color;
        logic signed [31:0]  fill_depth;
    } item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        action_t                      action;
        logic signed [15:0]           x0;
        logic signed [15:0]           y0;
        logic signed [31:0]           w0;
        logic signed [STEP_XY_W-1:0]  sx;
        logic signed [STEP_XY_W-1:0]  sy;
        logic signed [STEP_W_W-1:0]   sw;
        logic [LEN_W-1:0]             len;
        logic [7:0]                   color;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [COUNT_W-1:0] pixels_written;
        logic [7:0]         read_color;
        logic [31:0]        read_depth;
    } result_t;

endpackage

// ===== sv/dda_line_raster_depth_test.sv =====
`timescale 1ns / 1ps
// Line rasterizer with depth test over FB_WIDTH x FB_HEIGHT color and depth stores.
// Draw: step sizes by three divisions (x, y, w) in the front, then one pixel per cycle
// for length+1 pixels, then the pixel pipeline drains; fills sweep every store address.
// One item is worked at a time; the next is set up meanwhile. After reset a
// clearing pass over every store address zeroes both stores,
// with no beat accepted meanwhile; far_reciprocal resets to 167772.
module dda_line_raster_depth_test #(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_w, end_x, end_y, end_w, line_color, fill_depth
    input  logic [167:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixels_written, read_color, read_depth, zero padding
    output logic [63:0]  m_tdata
);
    import dda_pkg::*;

    logic [31:0] far_reg;
    item_t       item;
    cmd_t        front_cmd, fifo_cmd;
    logic        front_ready, front_push, fifo_full, fifo_valid, back_pop;
    logic        clearing;
    result_t     res;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg <= FAR_RESET;
        end
        else if (cfg_we)
        begin
            far_reg <= cfg_wdata;
        end
    end

    // Unpack the input beat.
    always_comb
    begin
        item.action     = action_t'(s_tuser);
        item.start_x    = s_tdata[15:0];
        item.start_y    = s_tdata[31:16];
        item.start_w    = s_tdata[63:32];
        item.end_x      = s_tdata[79:64];
        item.end_y      = s_tdata[95:80];
        item.end_w      = s_tdata[127:96];
        item.line_color = s_tdata[135:128];
        item.fill_depth = s_tdata[167:136];
    end

    assign s_tready = front_ready && !clearing;

    dda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && !clearing),
        .in_ready  (front_ready),
        .in_item   (item),
        .fifo_full (fifo_full),
        .push      (front_push),
        .cmd       (front_cmd)
    );

    dda_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (fifo_full),
        .pop       (back_pop),
        .not_empty (fifo_valid),
        .pop_data  (fifo_cmd)
    );

    dda_back #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .far_reciprocal (far_reg),
        .cmd_valid      (fifo_valid),
        .cmd            (fifo_cmd),
        .cmd_pop        (back_pop),
        .clearing       (clearing),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (res)
    );

    // Pack the result beat.
    assign m_tdata = {7'b0, res.read_depth, res.read_color, res.pixels_written};

endmodule

// ===== sv/dda_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module dda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dda_divider.sv =====
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Depends on dda_pkg for the operand widths.
module dda_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dda_pkg::DIV_W-1:0]  numer,
    input  logic [dda_pkg::LEN_W-1:0]  denom,
    output logic                       done,
    output logic [dda_pkg::DIV_W-1:0]  quot
);
    import dda_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic [LEN_W:0]   rem_shift;
    logic [LEN_W+1:0] rem_sub;

    // Trial subtraction of the divisor from the shifted remainder.
    assign rem_shift = {rem_reg, q_reg[DIV_W-1]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[LEN_W+1])
            begin
                rem_next = rem_sub[LEN_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[LEN_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== sv/dda_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and the back.
// Depends on dda_pkg for the command type and the queue depth.
module dda_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dda_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output dda_pkg::cmd_t  pop_data
);
    import dda_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             slot_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/dda_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, works out line length and step sizes, and
// queues a command for the back end. Depends on dda_pkg and dda_divider.
module dda_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dda_pkg::item_t in_item,
    input  logic           fifo_full,
    output logic           push,
    output dda_pkg::cmd_t  cmd
);
    import dda_pkg::*;

    front_state_t st_reg, st_next;
    div_sel_t     sel_reg, sel_next;
    item_t        item_reg, item_next;
    logic [16:0]  dx_reg, dx_next;
    logic [16:0]  dy_reg, dy_next;
    logic [32:0]  dw_reg, dw_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [STEP_XY_W-1:0] sx_reg, sx_next;
    logic [STEP_XY_W-1:0] sy_reg, sy_next;
    logic [STEP_W_W-1:0]  sw_reg, sw_next;

    logic [16:0]      dx_c, dy_c, ax_c, ay_c;
    logic [32:0]      dw_c;
    logic [LEN_W-1:0] len_c;
    logic [16:0]      adx, ady;
    logic [32:0]      adw;
    logic [DIV_W-1:0] div_mag, div_numer, div_quot;
    logic             div_start, div_done;
    logic [STEP_XY_W-1:0] q_xy;
    logic [STEP_W_W-1:0]  q_w;

    // Differences and major-axis length from the latched item.
    always_comb
    begin
        dx_c  = {item_reg.end_x[15], item_reg.end_x} - {item_reg.start_x[15], item_reg.start_x};
        dy_c  = {item_reg.end_y[15], item_reg.end_y} - {item_reg.start_y[15], item_reg.start_y};
        dw_c  = {item_reg.end_w[31], item_reg.end_w} - {item_reg.start_w[31], item_reg.start_w};
        ax_c  = dx_c[16] ? -dx_c : dx_c;
        ay_c  = dy_c[16] ? -dy_c : dy_c;
        len_c = (ax_c[15:0] > ay_c[15:0]) ? ax_c[15:0] : ay_c[15:0];
    end

    // Divider operand: magnitude of the difference plus half the length,
    // so the quotient rounds to nearest with ties away from zero.
    always_comb
    begin
        adx = dx_reg[16] ? -dx_reg : dx_reg;
        ady = dy_reg[16] ? -dy_reg : dy_reg;
        adw = dw_reg[32] ? -dw_reg : dw_reg;
        case (sel_reg)
            SEL_X:   div_mag = DIV_W'({adx[15:0], 16'h0000});
            SEL_Y:   div_mag = DIV_W'({ady[15:0], 16'h0000});
            SEL_W:   div_mag = DIV_W'(adw);
            default: div_mag = '0;
        endcase
        div_numer = div_mag + DIV_W'(len_reg >> 1);
    end

    dda_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (len_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_xy = {1'b0, div_quot[STEP_XY_W-2:0]};
    assign q_w  = {1'b0, div_quot[DIV_W-1:0]};

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = F_PREP;
                end
            end
            F_PREP:
            begin
                if (item_reg.action == ACT_DRAW && len_c != '0)
                begin
                    st_next = F_DSTART;
                end
                else
                begin
                    st_next = F_PUSH;
                end
            end
            F_DSTART: st_next = F_DWAIT;
            F_DWAIT:
            begin
                if (div_done)
                begin
                    st_next = (sel_reg == SEL_W) ? F_PUSH : F_DSTART;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    st_next = F_IDLE;
                end
            end
            default: st_next = F_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready  = (st_reg == F_IDLE);
        div_start = (st_reg == F_DSTART);
        push      = (st_reg == F_PUSH) && !fifo_full;
    end

    // Datapath registers.
    always_comb
    begin
        item_next = item_reg;
        sel_next  = sel_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        dw_next   = dw_reg;
        len_next  = len_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        sw_next   = sw_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                end
            end
            F_PREP:
            begin
                dx_next  = dx_c;
                dy_next  = dy_c;
                dw_next  = dw_c;
                len_next = len_c;
                sel_next = SEL_X;
                sx_next  = '0;
                sy_next  = '0;
                sw_next  = '0;
            end
            F_DWAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        SEL_X:
                        begin
                            sx_next  = dx_reg[16] ? -q_xy : q_xy;
                            sel_next = SEL_Y;
                        end
                        SEL_Y:
                        begin
                            sy_next  = dy_reg[16] ? -q_xy : q_xy;
                            sel_next = SEL_W;
                        end
                        default:
                        begin
                            sw_next = dw_reg[32] ? -q_w : q_w;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= F_IDLE;
            sel_reg <= SEL_X;
        end
        else
        begin
            st_reg  <= st_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dw_reg   <= dw_next;
        len_reg  <= len_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sw_reg   <= sw_next;
    end

    // Command handed to the queue.
    always_comb
    begin
        cmd.action = item_reg.action;
        cmd.x0     = item_reg.start_x;
        cmd.y0     = item_reg.start_y;
        cmd.w0     = (item_reg.action == ACT_FILL_DEPTH) ? item_reg.fill_depth
                                                         : item_reg.start_w;
        cmd.sx     = sx_reg;
        cmd.sy     = sy_reg;
        cmd.sw     = sw_reg;
        cmd.len    = len_reg;
        cmd.color  = item_reg.line_color;
    end

endmodule

// ===== sv/dda_back.sv =====
`timescale 1ns / 1ps
// Back end: walks lines through a pixel pipeline with the depth test, sweeps
// fills and the reset clear, serves reads. Depends on dda_pkg and dda_ram.
module dda_back #(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      far_reciprocal,
    input  logic             cmd_valid,
    input  dda_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output dda_pkg::result_t out_data
);
    import dda_pkg::*;

    localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int X_W        = $clog2(FB_WIDTH);
    localparam int Y_W        = $clog2(FB_HEIGHT);
    localparam int INT_W      = POS_W - FRAC_W;

    back_state_t st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;

    // Line walker.
    logic [POS_W-1:0]   cx_reg, cx_next;
    logic [POS_W-1:0]   cy_reg, cy_next;
    logic [WACC_W-1:0]  cw_reg, cw_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;

    // Pixel pipeline stages.
    logic              v1_reg, v2_reg, v3_reg;
    logic              hit1_reg, hit2_reg, hit3_reg;
    logic [ADDR_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]       mag1_reg;
    logic              neg1_reg, neg2_reg;
    logic [63:0]       prod2_reg;
    logic [31:0]       d3_reg;

    // Result and output register.
    result_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    logic [INT_W-1:0]  px, py;
    logic              on_px;
    logic [ADDR_W-1:0] pix_idx;
    logic [31:0]       ws, mag_w;
    logic [63:0]       prod, prod_rnd;
    logic [39:0]       q;
    logic [31:0]       d_new;
    logic              pass;
    logic              rd_on;
    logic [ADDR_W-1:0] rd_idx;
    logic              sweep_last;

    logic              depth_we, color_we, depth_re, color_re;
    logic [ADDR_W-1:0] depth_waddr, color_waddr, rd_addr;
    logic [31:0]       depth_wdata, depth_rdata;
    logic [7:0]        color_wdata, color_rdata;

    // Pixel coordinates truncated toward zero, bounds test and store index.
    always_comb
    begin
        px = cx_reg[POS_W-1:FRAC_W]
           + INT_W'(cx_reg[POS_W-1] && (cx_reg[FRAC_W-1:0] != '0));
        py = cy_reg[POS_W-1:FRAC_W]
           + INT_W'(cy_reg[POS_W-1] && (cy_reg[FRAC_W-1:0] != '0));
        on_px = !px[INT_W-1] && (px < INT_W'(FB_WIDTH))
             && !py[INT_W-1] && (py < INT_W'(FB_HEIGHT));
        pix_idx = ADDR_W'(py[Y_W-1:0]) * ADDR_W'(FB_WIDTH) + ADDR_W'(px[X_W-1:0]);
    end

    // Saturate w to 32 bits and split into sign and magnitude.
    always_comb
    begin
        if (cw_reg[WACC_W-1:31] == '0 || cw_reg[WACC_W-1:31] == '1)
        begin
            ws = cw_reg[31:0];
        end
        else
        begin
            ws = cw_reg[WACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        mag_w = ws[31] ? -ws : ws;
    end

    // Depth scaling: product, rounding shift, negation with saturation.
    always_comb
    begin
        prod     = mag1_reg * far_reciprocal;
        prod_rnd = prod2_reg + (64'd1 << (DEPTH_SHIFT - 1));
        q        = prod_rnd[63:DEPTH_SHIFT];
        if (neg2_reg)
        begin
            d_new = (q > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        else
        begin
            d_new = (q > 40'h00_8000_0000) ? 32'h8000_0000 : -q[31:0];
        end
    end

    // Depth test: write unless the stored depth is smaller.
    assign pass = v3_reg && hit3_reg && !($signed(depth_rdata) < $signed(d3_reg));

    // Read pixel address and bounds.
    always_comb
    begin
        rd_on  = !cmd_reg.x0[15] && (cmd_reg.x0 < 16'(FB_WIDTH))
              && !cmd_reg.y0[15] && (cmd_reg.y0 < 16'(FB_HEIGHT));
        rd_idx = ADDR_W'(cmd_reg.y0[Y_W-1:0]) * ADDR_W'(FB_WIDTH)
               + ADDR_W'(cmd_reg.x0[X_W-1:0]);
    end

    assign sweep_last = (sweep_reg == ADDR_W'(STORE_SIZE - 1));

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_CLEAR:
            begin
                if (sweep_last)
                begin
                    st_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.action)
                        ACT_DRAW: st_next = B_DRAW;
                        ACT_READ: st_next = B_READ;
                        default:  st_next = B_FILL;
                    endcase
                end
            end
            B_DRAW:
            begin
                if (cnt_reg == COUNT_W'(1))
                begin
                    st_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    st_next = B_DONE;
                end
            end
            B_FILL:
            begin
                if (sweep_last)
                begin
                    st_next = B_DONE;
                end
            end
            B_READ:      st_next = B_READ_DATA;
            B_READ_DATA: st_next = B_DONE;
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    st_next = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    // Outputs of the state machine: queue pop and store port control.
    always_comb
    begin
        cmd_pop     = (st_reg == B_IDLE) && cmd_valid;
        clearing    = (st_reg == B_CLEAR);
        depth_we    = pass;
        depth_waddr = idx3_reg;
        depth_wdata = d3_reg;
        color_we    = pass;
        color_waddr = idx3_reg;
        color_wdata = cmd_reg.color;
        case (st_reg)
            B_CLEAR:
            begin
                depth_we    = 1'b1;
                depth_waddr = sweep_reg;
                depth_wdata = '0;
                color_we    = 1'b1;
                color_waddr = sweep_reg;
                color_wdata = '0;
            end
            B_FILL:
            begin
                depth_we    = (cmd_reg.action == ACT_FILL_DEPTH);
                depth_waddr = sweep_reg;
                depth_wdata = cmd_reg.w0;
                color_we    = (cmd_reg.action == ACT_FILL_COLOR);
                color_waddr = sweep_reg;
            end
            default:
            begin
            end
        endcase
        rd_addr  = (st_reg == B_READ) ? rd_idx : idx2_reg;
        depth_re = (st_reg == B_READ) || (v2_reg && hit2_reg);
        color_re = (st_reg == B_READ);
    end

    // Datapath registers.
    always_comb
    begin
        cmd_next   = cmd_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cw_next    = cw_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg + COUNT_W'(pass);
        sweep_next = sweep_reg;
        res_next   = res_reg;
        case (st_reg)
            B_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cx_next    = {{(POS_W - 32){cmd.x0[15]}}, cmd.x0, 16'h0000};
                    cy_next    = {{(POS_W - 32){cmd.y0[15]}}, cmd.y0, 16'h0000};
                    cw_next    = {{(WACC_W - 32){cmd.w0[31]}}, cmd.w0};
                    cnt_next   = COUNT_W'(cmd.len) + 1'b1;
                    count_next = '0;
                    sweep_next = '0;
                    res_next   = '0;
                end
            end
            B_DRAW:
            begin
                cx_next  = cx_reg + {{(POS_W - STEP_XY_W){cmd_reg.sx[STEP_XY_W-1]}}, cmd_reg.sx};
                cy_next  = cy_reg + {{(POS_W - STEP_XY_W){cmd_reg.sy[STEP_XY_W-1]}}, cmd_reg.sy};
                cw_next  = cw_reg + {{(WACC_W - STEP_W_W){cmd_reg.sw[STEP_W_W-1]}}, cmd_reg.sw};
                cnt_next = cnt_reg - 1'b1;
            end
            B_DRAIN:
            begin
                res_next.pixels_written = count_reg;
            end
            B_FILL:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            B_READ_DATA:
            begin
                res_next.read_color = rd_on ? color_rdata : '0;
                res_next.read_depth = rd_on ? depth_rdata : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds a finished result until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (st_reg == B_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_CLEAR;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= (st_reg == B_DRAW);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cw_reg       <= cw_next;
        count_reg    <= count_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        hit1_reg     <= on_px;
        idx1_reg     <= pix_idx;
        mag1_reg     <= mag_w;
        neg1_reg     <= ws[31];
        hit2_reg     <= hit1_reg;
        idx2_reg     <= idx1_reg;
        prod2_reg    <= prod;
        neg2_reg     <= neg1_reg;
        hit3_reg     <= hit2_reg;
        idx3_reg     <= idx2_reg;
        d3_reg       <= d_new;
    end

    dda_ram #(
        .WIDTH (32),
        .DEPTH (STORE_SIZE)
    ) u_depth_ram (
        .clk   (clk),
        .we    (depth_we),
        .waddr (depth_waddr),
        .wdata (depth_wdata),
        .re    (depth_re),
        .raddr (rd_addr),
        .rdata (depth_rdata)
    );

    dda_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (color_waddr),
        .wdata (color_wdata),
        .re    (color_re),
        .raddr (rd_addr),
        .rdata (color_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
